/* src/ctks_pkg.sv */
// Package for the cosine top-k search block: sizes, status codes, shared types.
// Used by ctks_cell and cosine_topk_search; depends on nothing.
package ctks_pkg;

  localparam int MAX_DIM   = 64;
  localparam int CAPACITY  = 1024;
  localparam int MAX_TOP_K = 16;

  localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIMS_W = 7;
  localparam int ECNT_W = $clog2(MAX_DIM + 2);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ID_W   = 10;
  localparam int ROWI_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int ADDR_W = (CAPACITY * MAX_DIM > 1) ? $clog2(CAPACITY * MAX_DIM) : 1;
  localparam int K_W    = $clog2(MAX_TOP_K + 1);
  localparam int SUM_W  = 31 + $clog2(MAX_DIM + 1);
  localparam int RAD_W  = SUM_W + 20;
  localparam int ROOT_W = (RAD_W + 1) / 2;
  localparam int RB_W   = $clog2(ROOT_W);
  localparam int DIV_W  = ROOT_W + 17;
  localparam int ACC_W  = 33 + DIM_W;
  localparam int SCORE_W = 32;

  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_MATCH = 3'd1;
  localparam logic [2:0] ST_ZERO  = 3'd2;
  localparam logic [2:0] ST_LEN   = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;
  localparam logic [2:0] ST_NONE  = 3'd5;

  typedef struct packed {
    logic                      valid;
    logic signed [SCORE_W-1:0] score;
    logic [ID_W-1:0]           id;
  } ent_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } cell_ctl_t;

endpackage

/* src/ctks_cell.sv */
// One slot of the sorted best-match list: holds a score and id, takes a new
// candidate or its left neighbor's entry on insert, its right neighbor's on shift.
// Depends on ctks_pkg.
module ctks_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  ctks_pkg::cell_ctl_t ctl,
  input  ctks_pkg::ent_t     cand,
  input  ctks_pkg::ent_t     prev_ent,
  input  logic               prev_take,
  input  ctks_pkg::ent_t     next_ent,
  output ctks_pkg::ent_t     ent,
  output logic               take
);

  ctks_pkg::ent_t ent_r, ent_nxt;

  assign take = ctl.insert & (!ent_r.valid || (cand.score > ent_r.score));
  assign ent  = ent_r;

  always_comb begin
    priority if (ctl.clear) begin
      ent_nxt       = ent_r;
      ent_nxt.valid = 1'b0;
    end else if (ctl.shift) begin
      ent_nxt = next_ent;
    end else if (take) begin
      ent_nxt = prev_take ? prev_ent : cand;
    end else begin
      ent_nxt = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

/* src/cosine_topk_search.sv */
// Top level of the cosine top-k search: element intake, norm, normalization,
// store scan and the chain of best-match cells. Depends on ctks_pkg, ctks_cell.
//
//  channel | ports                       | carries
//  --------+-----------------------------+---------------------------------------
//  in      | in_tvalid/tready/tdata/...  | one vector element (add or query)
//  out     | out_tvalid/tready/tdata/... | one result: status, id, score
//  cfg     | cfg_wr_en, cfg_wr_data      | dimension_count register
//
// Elements are taken one per cycle while idle. After the last element the block
// stops taking items: a decision state (an error or no-result answer goes out
// right after it), a square root (one root bit a cycle), then per vector slot
// the states S_NRD, S_NLD and S_NWR plus up to 15 divide steps (MAX_DIM slots;
// slots past the length and saturating elements skip the divide), and for a
// query a scan of dimension_count elements of every stored vector through the
// single read port of the vector store, then a drain of the scan pipeline.
// Results then leave one per cycle while out_tready is high; a stall holds them.
// Reset (rst_n low, synchronous) empties the store and sets dimension_count to 64.
module cosine_topk_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,   // dimension_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // [15:0] element_value, [20:16] requested_k, zero pad
  input  logic        in_tuser,      // opcode
  input  logic        in_tlast,      // last_element
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,     // [9:0] vector_id, [41:10] similarity, zero pad
  output logic [2:0]  out_tuser,     // status
  output logic        out_tlast      // last_result
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_SQRT, S_NRD, S_NLD, S_NDIV, S_NWR, S_SCAN, S_OUT, S_RESP
  } state_t;

  localparam int DIM_W  = ctks_pkg::DIM_W;
  localparam int DIMS_W = ctks_pkg::DIMS_W;
  localparam int ECNT_W = ctks_pkg::ECNT_W;
  localparam int CNT_W  = ctks_pkg::CNT_W;
  localparam int ID_W   = ctks_pkg::ID_W;
  localparam int ADDR_W = ctks_pkg::ADDR_W;
  localparam int K_W    = ctks_pkg::K_W;
  localparam int SUM_W  = ctks_pkg::SUM_W;
  localparam int RAD_W  = ctks_pkg::RAD_W;
  localparam int ROOT_W = ctks_pkg::ROOT_W;
  localparam int RB_W   = ctks_pkg::RB_W;
  localparam int DIV_W  = ctks_pkg::DIV_W;
  localparam int ACC_W  = ctks_pkg::ACC_W;
  localparam int SC_W   = ctks_pkg::SCORE_W;
  localparam int NK     = ctks_pkg::MAX_TOP_K;

  // storage
  logic signed [15:0] stage_mem [ctks_pkg::MAX_DIM];
  logic signed [15:0] qbuf_mem  [ctks_pkg::MAX_DIM];
  logic signed [15:0] vec_mem   [ctks_pkg::CAPACITY * ctks_pkg::MAX_DIM];

  state_t state_r;
  logic [DIMS_W-1:0] dims_r;
  logic [ECNT_W-1:0] ecnt_r, cnt_r;
  logic [SUM_W-1:0]  sum_r;
  logic [RAD_W-1:0]  rad_r;
  logic [CNT_W-1:0]  stored_r;
  logic              op_r;
  logic [4:0]        k_r;
  logic [K_W-1:0]    want_r;
  logic [ROOT_W-1:0] root_r;
  logic [RB_W-1:0]   rbit_r;
  logic [DIM_W-1:0]  d_r;
  logic [DIV_W-1:0]  rem_r, div_r;
  logic [14:0]       q_r;
  logic [3:0]        qbit_r;
  logic              neg_r;
  logic [2:0]        resp_r;
  logic [ID_W-1:0]   resp_id_r;
  logic [K_W-1:0]    left_r;
  logic signed [15:0] stg_q, qb_q, vs_q;

  // scan pipeline
  logic              issue_r;
  logic [CNT_W-1:0]  sid_r;
  logic [DIM_W-1:0]  sd_r;
  logic              p1_vld_r, p1_first_r, p1_last_r;
  logic [ID_W-1:0]   p1_id_r;
  logic              p2_vld_r, p2_first_r, p2_last_r;
  logic [ID_W-1:0]   p2_id_r;
  logic signed [31:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic              cand_vld_r;
  logic signed [SC_W-1:0] cand_score_r;
  logic [ID_W-1:0]   cand_id_r;

  // intake
  logic               in_acc;
  logic signed [15:0] x_in;
  logic [ECNT_W-1:0]  ecnt_inc;
  logic signed [31:0] sq_in;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign x_in      = in_tdata[15:0];
  assign sq_in     = x_in * x_in;
  assign ecnt_inc  = (ecnt_r < ECNT_W'(ctks_pkg::MAX_DIM + 1)) ? ecnt_r + 1'b1 : ecnt_r;

  always_ff @(posedge clk) begin
    if (in_acc && ecnt_r < ECNT_W'(ctks_pkg::MAX_DIM)) begin
      stage_mem[ecnt_r[DIM_W-1:0]] <= x_in;
    end
    stg_q <= stage_mem[d_r];
  end

  // decision inputs
  logic len_ok;
  logic [4:0] k_cl;
  assign len_ok = (dims_r >= DIMS_W'(1)) && (dims_r <= DIMS_W'(ctks_pkg::MAX_DIM))
                  && (ECNT_W'(dims_r) == cnt_r) && (cnt_r == ECNT_W'(dims_r));
  assign k_cl   = (k_r > 5'(NK)) ? 5'(NK) : k_r;

  // square root step: try one more root bit
  logic [ROOT_W-1:0]   root_try;
  logic [2*ROOT_W-1:0] root_sq;
  assign root_try = root_r | (ROOT_W'(1) << rbit_r);
  assign root_sq  = root_try * root_try;

  // normalization inputs
  logic [16:0]      mag;
  logic [DIV_W-1:0] numer, n_sh15;
  logic [15:0]      uval;
  assign mag    = stg_q[15] ? 17'(-$signed({stg_q[15], stg_q})) : 17'({1'b0, stg_q});
  assign numer  = (DIV_W'(mag) << 25) + DIV_W'(root_r >> 1);
  assign n_sh15 = DIV_W'(root_r) << 15;
  assign uval   = neg_r ? 16'(-$signed({1'b0, q_r})) : {1'b0, q_r};

  // scan address and accumulation
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              issue_last_d;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [SC_W-1:0]  acc_sat;
  assign rd_addr      = ADDR_W'(sid_r * ctks_pkg::MAX_DIM) + ADDR_W'(sd_r);
  assign wr_addr      = ADDR_W'(stored_r * ctks_pkg::MAX_DIM) + ADDR_W'(d_r);
  assign issue_last_d = (DIMS_W'(sd_r) == dims_r - 1'b1);
  assign acc_sum      = (p2_first_r ? ACC_W'(0) : acc_r) + ACC_W'(prod_r);
  always_comb begin
    if (acc_sum > ACC_W'(signed'(64'sd1 <<< 30))) begin
      acc_sat = SC_W'(32'sd1 <<< 30);
    end else if (acc_sum < -ACC_W'(signed'(64'sd1 <<< 30))) begin
      acc_sat = -SC_W'(32'sd1 <<< 30);
    end else begin
      acc_sat = SC_W'(acc_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_NWR) begin
      if (op_r) begin
        qbuf_mem[d_r] <= uval;
      end else begin
        vec_mem[wr_addr] <= uval;
      end
    end
    vs_q <= vec_mem[rd_addr];
    qb_q <= qbuf_mem[sd_r];
  end

  // chain of best-match cells
  ctks_pkg::cell_ctl_t ctl;
  ctks_pkg::ent_t      cand;
  ctks_pkg::ent_t      ents [NK];
  logic [NK-1:0]       takes;
  logic                out_acc;

  assign out_acc     = out_tvalid & out_tready;
  assign ctl.clear   = (state_r == S_DECIDE);
  assign ctl.insert  = cand_vld_r;
  assign ctl.shift   = (state_r == S_OUT) && out_acc;
  assign cand.valid  = 1'b1;
  assign cand.score  = cand_score_r;
  assign cand.id     = cand_id_r;

  for (genvar i = 0; i < NK; i++) begin : g_cell
    ctks_pkg::ent_t pe, ne;
    logic           pt;
    if (i == 0) begin : g_head
      assign pe = '0;
      assign pt = 1'b0;
    end else begin : g_body
      assign pe = ents[i-1];
      assign pt = takes[i-1];
    end
    if (i == NK - 1) begin : g_tail
      assign ne = '0;
    end else begin : g_mid
      assign ne = ents[i+1];
    end
    ctks_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .cand      (cand),
      .prev_ent  (pe),
      .prev_take (pt),
      .next_ent  (ne),
      .ent       (ents[i]),
      .take      (takes[i])
    );
  end

  // result channel
  always_comb begin
    out_tvalid = 1'b0;
    out_tuser  = resp_r;
    out_tdata  = '0;
    out_tlast  = 1'b1;
    unique case (state_r)
      S_OUT: begin
        out_tvalid        = 1'b1;
        out_tuser         = ctks_pkg::ST_MATCH;
        out_tdata[9:0]    = ents[0].id;
        out_tdata[41:10]  = ents[0].score;
        out_tlast         = (left_r == K_W'(1));
      end
      S_RESP: begin
        out_tvalid     = 1'b1;
        out_tdata[9:0] = resp_id_r;
      end
      default: begin
        out_tvalid = 1'b0;
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      dims_r     <= DIMS_W'(64);
      ecnt_r     <= '0;
      sum_r      <= '0;
      stored_r   <= '0;
      issue_r    <= 1'b0;
      p1_vld_r   <= 1'b0;
      p2_vld_r   <= 1'b0;
      cand_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        dims_r <= cfg_wr_data;
      end

      // scan pipeline advances on its own
      p1_vld_r   <= issue_r;
      p1_first_r <= (sd_r == '0);
      p1_last_r  <= issue_last_d;
      p1_id_r    <= sid_r[ID_W-1:0];
      p2_vld_r   <= p1_vld_r;
      p2_first_r <= p1_first_r;
      p2_last_r  <= p1_last_r;
      p2_id_r    <= p1_id_r;
      prod_r     <= qb_q * vs_q;
      cand_vld_r <= p2_vld_r && p2_last_r;
      if (p2_vld_r) begin
        acc_r <= acc_sum;
        if (p2_last_r) begin
          cand_score_r <= acc_sat;
          cand_id_r    <= p2_id_r;
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (ecnt_r < ECNT_W'(ctks_pkg::MAX_DIM)) begin
              sum_r <= sum_r + SUM_W'(unsigned'(sq_in));
            end
            if (in_tlast) begin
              ecnt_r  <= '0;
              cnt_r   <= ecnt_inc;
              op_r    <= in_tuser;
              k_r     <= in_tdata[20:16];
              state_r <= S_DECIDE;
            end else begin
              ecnt_r <= ecnt_inc;
            end
          end
        end
        S_DECIDE: begin
          rad_r  <= RAD_W'(sum_r) << 20;
          sum_r  <= '0;
          root_r <= '0;
          rbit_r <= RB_W'(ROOT_W - 1);
          d_r    <= '0;
          want_r <= (CNT_W'(k_cl) > stored_r) ? K_W'(stored_r) : K_W'(k_cl);
          resp_id_r <= '0;
          priority if (!len_ok) begin
            resp_r <= ctks_pkg::ST_LEN;  state_r <= S_RESP;
          end else if (op_r && (k_r == '0 || stored_r == '0)) begin
            resp_r <= ctks_pkg::ST_NONE; state_r <= S_RESP;
          end else if (sum_r == '0) begin
            resp_r <= ctks_pkg::ST_ZERO; state_r <= S_RESP;
          end else if (!op_r && stored_r >= CNT_W'(ctks_pkg::CAPACITY)) begin
            resp_r <= ctks_pkg::ST_FULL; state_r <= S_RESP;
          end else begin
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (RAD_W'(root_sq) <= rad_r && (2*ROOT_W)'(rad_r) >= root_sq) begin
            root_r <= root_try;
          end
          rbit_r <= rbit_r - 1'b1;
          if (rbit_r == '0) begin
            state_r <= S_NRD;
          end
        end
        S_NRD: begin
          state_r <= S_NLD;  // staging read settles
        end
        S_NLD: begin
          neg_r  <= stg_q[15];
          rem_r  <= numer;
          div_r  <= DIV_W'(root_r) << 14;
          qbit_r <= 4'd14;
          priority if (DIMS_W'(d_r) >= dims_r || (DIM_W + 1)'(d_r) >= (DIM_W + 1)'(dims_r)) begin
            q_r     <= '0;
            state_r <= S_NWR;
          end else if (numer >= n_sh15) begin
            q_r     <= 15'h7fff;
            state_r <= S_NWR;
          end else begin
            q_r     <= '0;
            state_r <= S_NDIV;
          end
        end
        S_NDIV: begin
          if (rem_r >= div_r) begin
            rem_r       <= rem_r - div_r;
            q_r[qbit_r] <= 1'b1;
          end
          div_r  <= div_r >> 1;
          qbit_r <= qbit_r - 1'b1;
          if (qbit_r == 4'd0) begin
            state_r <= S_NWR;
          end
        end
        S_NWR: begin
          d_r <= d_r + 1'b1;
          if (d_r == DIM_W'(ctks_pkg::MAX_DIM - 1)) begin
            if (op_r) begin
              sid_r   <= '0;
              sd_r    <= '0;
              issue_r <= 1'b1;
              state_r <= S_SCAN;
            end else begin
              resp_r    <= ctks_pkg::ST_ADDED;
              resp_id_r <= stored_r[ID_W-1:0];
              stored_r  <= stored_r + 1'b1;
              state_r   <= S_RESP;
            end
          end else begin
            state_r <= S_NRD;
          end
        end
        S_SCAN: begin
          if (issue_r) begin
            if (issue_last_d) begin
              sd_r  <= '0;
              sid_r <= sid_r + 1'b1;
              if (sid_r == stored_r - 1'b1) begin
                issue_r <= 1'b0;
              end
            end else begin
              sd_r <= sd_r + 1'b1;
            end
          end else if (!p1_vld_r && !p2_vld_r && !cand_vld_r) begin
            left_r  <= want_r;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            left_r <= left_r - 1'b1;
            if (left_r == K_W'(1)) begin
              state_r <= S_IDLE;
            end
          end
        end
        S_RESP: begin
          if (out_acc) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
